// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the queue.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define SSPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SSPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sspq_pkg.sv =====
// Package of the severity priority queue: widths, codes and beat types.
// No dependencies; used by every module of the queue.
`default_nettype none

package sspq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_W         = 16;
  localparam int SEV_W        = 3;
  localparam int STATUS_W     = 3;
  localparam int OCC_W        = 7;

  localparam logic [SEV_W-1:0] SEV_MIN = 3'd1;
  localparam logic [SEV_W-1:0] SEV_MAX = 3'd5;
  localparam logic [SEV_W-1:0] SEV_TOP = 3'd7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADSEV   = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SEV_W-1:0] sev;
  } sspq_entry_t;

  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [ID_W-1:0]  id;
    logic [SEV_W-1:0] sev;
  } sspq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/stable_severity_priority_queue.sv =====
// Sorted priority queue built as a chain of CAPACITY cells.
// The result beat is registered and comes in the cycle after the command is taken.
// Throughput: one command per cycle; busy stays low, every slot shifts at once.
// Reset: entry count and result strobe clear; slot contents are left as is.
// The receiver cannot stall: each result beat lasts one cycle.
`default_nettype none

module stable_severity_priority_queue #(
  parameter int CAPACITY = sspq_pkg::CAPACITY_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire                               in_command,
  input  wire  [sspq_pkg::ID_W-1:0]         in_patient_id,
  input  wire  [sspq_pkg::SEV_W-1:0]        in_severity,
  output logic                              out_valid,
  output logic [sspq_pkg::STATUS_W-1:0]     out_status,
  output logic [sspq_pkg::ID_W-1:0]         out_id,
  output logic [sspq_pkg::SEV_W-1:0]        out_severity,
  output logic [sspq_pkg::OCC_W-1:0]        out_occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                             accept;
  logic                             sev_ok;
  logic                             full;
  logic                             empty;
  sspq_pkg::sspq_cmd_t              cmd;
  logic [CNT_W-1:0]                 cnt_r;
  logic [CNT_W-1:0]                 cnt_nxt;
  logic [CNT_W+sspq_pkg::OCC_W-1:0] cnt_ext;
  logic                             valid_r;
  logic [sspq_pkg::STATUS_W-1:0]    status_r;
  logic [sspq_pkg::STATUS_W-1:0]    status_nxt;
  logic [sspq_pkg::ID_W-1:0]        id_r;
  logic [sspq_pkg::ID_W-1:0]        id_nxt;
  logic [sspq_pkg::SEV_W-1:0]       sev_r;
  logic [sspq_pkg::SEV_W-1:0]       sev_nxt;
  logic [sspq_pkg::OCC_W-1:0]       occ_r;

  sspq_pkg::sspq_entry_t            ents [CAPACITY];
  logic                             occ  [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign sev_ok = (in_severity >= sspq_pkg::SEV_MIN) && (in_severity <= sspq_pkg::SEV_MAX);
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign empty  = (cnt_r == '0);

  always_comb begin
    cmd.ins    = accept && (in_command == sspq_pkg::CMD_INSERT) && sev_ok && !full;
    cmd.pop    = accept && (in_command == sspq_pkg::CMD_POP) && !empty;
    cmd.id     = in_patient_id;
    cmd.sev    = in_severity;
    cnt_nxt    = cnt_r;
    status_nxt = sspq_pkg::ST_INSERTED;
    id_nxt     = '0;
    sev_nxt    = '0;
    case (in_command)
      sspq_pkg::CMD_INSERT: begin
        if (!sev_ok) begin
          status_nxt = sspq_pkg::ST_BADSEV;
        end else if (full) begin
          status_nxt = sspq_pkg::ST_FULL;
        end else begin
          status_nxt = sspq_pkg::ST_INSERTED;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      sspq_pkg::CMD_POP: begin
        if (empty) begin
          status_nxt = sspq_pkg::ST_EMPTY;
        end else begin
          status_nxt = sspq_pkg::ST_POPPED;
          id_nxt     = ents[0].id;
          sev_nxt    = ents[0].sev;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      default: begin
        status_nxt = sspq_pkg::ST_INSERTED;
      end
    endcase
  end

  assign cnt_ext = {{sspq_pkg::OCC_W{1'b0}}, cnt_nxt};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      sspq_pkg::sspq_entry_t left_ent;
      sspq_pkg::sspq_entry_t right_ent;
      logic                  left_occ;

      assign occ[gi] = (CNT_W'(gi) < cnt_r);

      if (gi == 0) begin : g_head
        assign left_occ = 1'b1;
        assign left_ent = {{sspq_pkg::ID_W{1'b0}}, sspq_pkg::SEV_TOP};
      end else begin : g_body
        assign left_occ = occ[gi-1];
        assign left_ent = ents[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign right_ent = '0;
      end else begin : g_link
        assign right_ent = ents[gi+1];
      end

      sspq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .left_occ  (left_occ),
        .left_ent  (left_ent),
        .right_ent (right_ent),
        .self_occ  (occ[gi]),
        .ent       (ents[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      id_r     <= id_nxt;
      sev_r    <= sev_nxt;
      occ_r    <= cnt_ext[sspq_pkg::OCC_W-1:0];
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_id        = id_r;
  assign out_severity  = sev_r;
  assign out_occupancy = occ_r;

endmodule

`default_nettype wire

// ===== rtl/core/sspq_cell.sv =====
// One slot of the sorted chain: holds an entry, takes the new one, its left
// neighbor on insert, or its right neighbor on pop. Depends on sspq_pkg.
`default_nettype none

module sspq_cell (
  input  wire                          clk,
  input  wire sspq_pkg::sspq_cmd_t     cmd,
  input  wire                          left_occ,
  input  wire sspq_pkg::sspq_entry_t   left_ent,
  input  wire sspq_pkg::sspq_entry_t   right_ent,
  input  wire                          self_occ,
  output sspq_pkg::sspq_entry_t        ent
);

  sspq_pkg::sspq_entry_t ent_r;
  sspq_pkg::sspq_entry_t ent_nxt;
  logic                  left_ge;
  logic                  left_lt;
  logic                  self_lt;

  assign left_ge = left_occ && (left_ent.sev >= cmd.sev);
  assign left_lt = left_occ && (left_ent.sev < cmd.sev);
  assign self_lt = !self_occ || (ent_r.sev < cmd.sev);

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins) begin
      if (left_ge && self_lt) begin
        ent_nxt.id  = cmd.id;
        ent_nxt.sev = cmd.sev;
      end else if (left_lt) begin
        ent_nxt = left_ent;
      end
    end else if (cmd.pop) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

// ===== rtl/core/sspq_chk.sv =====
// Port-level checker of the severity priority queue, bound to the top level.
// Depends on sspq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sspq_chk (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            start,
  input wire                            busy,
  input wire                            out_valid,
  input wire [sspq_pkg::STATUS_W-1:0]   out_status,
  input wire [sspq_pkg::ID_W-1:0]       out_id,
  input wire [sspq_pkg::SEV_W-1:0]      out_severity,
  input wire [sspq_pkg::OCC_W-1:0]      out_occupancy
);

  `SSPQ_ASSERT_NEXT(a_beat_follows, start && !busy, out_valid, "missing result beat")
  `SSPQ_ASSERT_NEXT(a_no_extra_beat, !(start && !busy), !out_valid, "result beat without command")
  `SSPQ_ASSERT_NOW(a_zero_fields, out_valid && (out_status != sspq_pkg::ST_POPPED), (out_id == '0) && (out_severity == '0), "nonzero fields on non-pop result")
  `SSPQ_ASSERT_NOW(a_pop_sev, out_valid && (out_status == sspq_pkg::ST_POPPED), (out_severity >= sspq_pkg::SEV_MIN) && (out_severity <= sspq_pkg::SEV_MAX), "popped severity out of range")
  `SSPQ_ASSERT_NOW(a_empty_occ, out_valid && (out_status == sspq_pkg::ST_EMPTY), out_occupancy == '0, "empty status with entries held")

endmodule

bind stable_severity_priority_queue sspq_chk u_sspq_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_id        (out_id),
  .out_severity  (out_severity),
  .out_occupancy (out_occupancy)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for stable_severity_priority_queue: directed, fill/drain and random beats.
// Predicts each result from its own sorted model; needs sspq_pkg and the queue RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF_PERIOD      = 6;
  localparam int RESET_CYCLES     = 11;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int TAIL_CYCLES      = 4;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int QUEUE_DEPTH      = sspq_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic [sspq_pkg::STATUS_W-1:0] status;
    logic [sspq_pkg::ID_W-1:0]     id;
    logic [sspq_pkg::SEV_W-1:0]    sev;
    logic [sspq_pkg::OCC_W-1:0]    occupancy;
  } cmd_result_t;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          start         = 1'b0;
  logic                          in_command    = sspq_pkg::CMD_INSERT;
  logic [sspq_pkg::ID_W-1:0]     in_patient_id = '0;
  logic [sspq_pkg::SEV_W-1:0]    in_severity   = '0;
  logic                          busy;
  logic                          out_valid;
  logic [sspq_pkg::STATUS_W-1:0] out_status;
  logic [sspq_pkg::ID_W-1:0]     out_id;
  logic [sspq_pkg::SEV_W-1:0]    out_severity;
  logic [sspq_pkg::OCC_W-1:0]    out_occupancy;

  logic [sspq_pkg::ID_W-1:0]  model_ids  [QUEUE_DEPTH];
  logic [sspq_pkg::SEV_W-1:0] model_sevs [QUEUE_DEPTH];
  int                         model_count = 0;

  cmd_result_t command_results_due[$];
  cmd_result_t oldest_result;
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  stable_severity_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_patient_id(in_patient_id),
    .in_severity  (in_severity),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_id       (out_id),
    .out_severity (out_severity),
    .out_occupancy(out_occupancy)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic void track_sorted_queue(input logic cmd,
                                             input logic [sspq_pkg::ID_W-1:0] id,
                                             input logic [sspq_pkg::SEV_W-1:0] sev);
    cmd_result_t beat;
    int          slot;
    beat = '0;
    if (cmd == sspq_pkg::CMD_INSERT) begin
      if (sev < sspq_pkg::SEV_MIN || sev > sspq_pkg::SEV_MAX) begin
        beat.status = sspq_pkg::ST_BADSEV;
      end else if (model_count >= QUEUE_DEPTH) begin
        beat.status = sspq_pkg::ST_FULL;
      end else begin
        slot = model_count;
        while (slot > 0 && model_sevs[slot-1] < sev) begin
          model_ids[slot]  = model_ids[slot-1];
          model_sevs[slot] = model_sevs[slot-1];
          slot--;
        end
        model_ids[slot]  = id;
        model_sevs[slot] = sev;
        model_count++;
        beat.status = sspq_pkg::ST_INSERTED;
      end
    end else if (model_count == 0) begin
      beat.status = sspq_pkg::ST_EMPTY;
    end else begin
      beat.id  = model_ids[0];
      beat.sev = model_sevs[0];
      for (slot = 1; slot < model_count; slot++) begin
        model_ids[slot-1]  = model_ids[slot];
        model_sevs[slot-1] = model_sevs[slot];
      end
      model_count--;
      beat.status = sspq_pkg::ST_POPPED;
    end
    beat.occupancy = model_count[sspq_pkg::OCC_W-1:0];
    command_results_due.push_back(beat);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (command_results_due.size() == 0) begin
        if (mismatch_count < SHOWN_MISMATCHES)
          $display("unexpected beat: status %0d id %h sev %0d occ %0d",
                   out_status, out_id, out_severity, out_occupancy);
        mismatch_count++;
      end else begin
        oldest_result = command_results_due.pop_front();
        if (out_status !== oldest_result.status || out_id !== oldest_result.id ||
            out_severity !== oldest_result.sev || out_occupancy !== oldest_result.occupancy) begin
          if (mismatch_count < SHOWN_MISMATCHES)
            $display("mismatch: want status %0d id %h sev %0d occ %0d, got %0d %h %0d %0d",
                     oldest_result.status, oldest_result.id, oldest_result.sev,
                     oldest_result.occupancy, out_status, out_id, out_severity,
                     out_occupancy);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [sspq_pkg::ID_W-1:0] id,
                           input logic [sspq_pkg::SEV_W-1:0] sev);
    start         <= 1'b1;
    in_command    <= cmd;
    in_patient_id <= id;
    in_severity   <= sev;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_sorted_queue(cmd, id, sev);
  endtask

  task automatic insert_valid(input int sev);
    logic [31:0] rnd;
    rnd = $urandom();
    send_beat(sspq_pkg::CMD_INSERT, rnd[sspq_pkg::ID_W-1:0], sev[sspq_pkg::SEV_W-1:0]);
  endtask

  task automatic insert_bad();
    logic [sspq_pkg::SEV_W-1:0] sev;
    logic [31:0]                rnd;
    rnd = $urandom();
    case ($urandom_range(0, 2))
      0: sev = 3'd0;
      1: sev = sspq_pkg::SEV_MAX + 3'd1;
      default: sev = sspq_pkg::SEV_TOP;
    endcase
    send_beat(sspq_pkg::CMD_INSERT, rnd[sspq_pkg::ID_W-1:0], sev);
  endtask

  task automatic pop_entry();
    logic [31:0] rnd;
    rnd = $urandom();
    send_beat(sspq_pkg::CMD_POP, rnd[sspq_pkg::ID_W-1:0],
              rnd[sspq_pkg::ID_W +: sspq_pkg::SEV_W]);
  endtask

  task automatic maybe_idle(input bit enabled);
    if (enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (command_results_due.size() != 0) @(posedge clk);
  endtask

  // Bad severities, empty pops, id extremes and equal-severity ordering.
  task automatic test_directed();
    send_beat(sspq_pkg::CMD_POP, 16'hFFFF, sspq_pkg::SEV_TOP);
    maybe_idle(1);
    send_beat(sspq_pkg::CMD_INSERT, 16'h0000, 3'd0);
    send_beat(sspq_pkg::CMD_INSERT, 16'hFFFF, 3'd6);
    send_beat(sspq_pkg::CMD_INSERT, 16'hAAAA, sspq_pkg::SEV_TOP);
    maybe_idle(1);
    send_beat(sspq_pkg::CMD_INSERT, 16'h0000, sspq_pkg::SEV_MIN);
    send_beat(sspq_pkg::CMD_INSERT, 16'hFFFF, sspq_pkg::SEV_MAX);
    send_beat(sspq_pkg::CMD_INSERT, 16'h1111, 3'd3);
    maybe_idle(1);
    send_beat(sspq_pkg::CMD_INSERT, 16'h2222, 3'd3);
    send_beat(sspq_pkg::CMD_INSERT, 16'h3333, sspq_pkg::SEV_MAX);
    send_beat(sspq_pkg::CMD_INSERT, 16'h4444, sspq_pkg::SEV_MIN);
    send_beat(sspq_pkg::CMD_INSERT, 16'h5555, 3'd3);
    maybe_idle(1);
    repeat (7) begin
      pop_entry();
      maybe_idle(1);
    end
    pop_entry();
    send_beat(sspq_pkg::CMD_INSERT, 16'hAAAA, 3'd0);
    wait_drained();
  endtask

  // Fill to capacity, hit the full and bad-severity paths, then drain past empty.
  task automatic test_fill_and_drain();
    for (int round = 0; round < 3; round++) begin
      while (model_count < QUEUE_DEPTH) begin
        if ($urandom_range(0, 9) == 0)
          insert_bad();
        else
          insert_valid(round == 1 ? 3 :
                       round == 2 ? 1 + (model_count * 5) / QUEUE_DEPTH :
                       $urandom_range(1, 5));
        maybe_idle(1);
      end
      repeat (3) insert_valid($urandom_range(1, 5));
      insert_bad();
      pop_entry();
      insert_valid(sspq_pkg::SEV_MAX);
      insert_valid(sspq_pkg::SEV_MIN);
      while (model_count > 0) begin
        pop_entry();
        maybe_idle(round != 2);
      end
      pop_entry();
      pop_entry();
    end
  endtask

  task automatic test_random_mix();
    int insert_pct;
    for (int seg = 0; seg < 16; seg++) begin
      insert_pct = (seg % 3 == 0) ? 30 : (seg % 3 == 1) ? 70 : 50;
      repeat (50) begin
        if ($urandom_range(0, 99) < insert_pct) begin
          if ($urandom_range(0, 9) == 0)
            insert_bad();
          else
            insert_valid($urandom_range(1, 5));
        end else begin
          pop_entry();
        end
        maybe_idle(seg % 4 != 3);
      end
      if (seg == 7)
        wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    repeat (300) begin
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 9) == 0)
          insert_bad();
        else
          insert_valid($urandom_range(1, 5));
      end else begin
        pop_entry();
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_and_drain();
    test_random_mix();
    test_back_to_back();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && command_results_due.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
